FILE: design/aocc_pkg.sv
// shared constants, types and helpers for the accelerometer offset calibration block
`timescale 1ns / 1ps
package aocc_pkg;

  localparam int unsigned CAL_SAMPLES  = 20;
  localparam int unsigned WORD_W       = 16;
  localparam int unsigned SAMPLE_SHIFT = 4;
  localparam int unsigned SAMPLE_W     = WORD_W - SAMPLE_SHIFT;
  localparam int unsigned VAL_W        = 14;
  localparam int unsigned WIDE_W       = VAL_W + 2;
  localparam int unsigned TOT_W        = 20;
  localparam int unsigned G_W          = 13;
  localparam logic [G_W-1:0] G_RESET   = G_W'(1024);
  localparam int unsigned CNT_W        = $clog2(CAL_SAMPLES + 1);
  localparam int unsigned NUM_AXES     = 3;

  // width of the largest magnitude a calibration total can reach
  localparam int unsigned ABS_W        = $clog2(CAL_SAMPLES * (2 ** (SAMPLE_W - 1)) + 1);
  localparam int unsigned QUO_W        = SAMPLE_W;
  localparam int unsigned RECIP_SHIFT  = ABS_W + 1;
  localparam int unsigned RECIP_W      = RECIP_SHIFT + 1;
  localparam int unsigned RECIP        = (2 ** RECIP_SHIFT) / CAL_SAMPLES;
  localparam int unsigned PROD_W       = ABS_W + RECIP_W;

  localparam int unsigned QDEPTH       = 4;
  localparam int unsigned QPTR_W       = $clog2(QDEPTH);
  localparam int unsigned QCNT_W       = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic                                cal;
    logic                                last;
    logic [NUM_AXES-1:0][SAMPLE_W-1:0]   smp;
  } cmd_t;

  typedef struct packed {
    logic [NUM_AXES-1:0][VAL_W-1:0] val;
    logic                           done;
  } res_t;

  typedef enum logic [4:0] {
    ST_RUN   = 5'b00001,
    ST_ABS   = 5'b00010,
    ST_MUL   = 5'b00100,
    ST_FIX   = 5'b01000,
    ST_APPLY = 5'b10000
  } div_state_e;

  localparam logic signed [WIDE_W-1:0] VAL_MIN = -(WIDE_W'(2 ** (VAL_W - 1)));
  localparam logic signed [WIDE_W-1:0] VAL_MAX = WIDE_W'(2 ** (VAL_W - 1) - 1);

  function automatic logic [VAL_W-1:0] sat_val(input logic signed [WIDE_W-1:0] v);
    logic [VAL_W-1:0] r;
    if (v < VAL_MIN) begin
      r = VAL_MIN[VAL_W-1:0];
    end else if (v > VAL_MAX) begin
      r = VAL_MAX[VAL_W-1:0];
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: design/aocc_front.sv
// front end: takes input beats, extracts samples and tags calibration beats
`timescale 1ns / 1ps
module aocc_front import aocc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic              opcode_i,
  input  logic [WORD_W-1:0] x_word_i,
  input  logic [WORD_W-1:0] y_word_i,
  input  logic [WORD_W-1:0] z_word_i,
  input  logic              q_full_i,
  output logic              q_wr_o,
  output cmd_t              q_wdata_o
);

  logic             accept;
  logic             last;
  logic [CNT_W-1:0] cnt_d, cnt_q;

  assign full   = q_full_i;
  assign accept = push & ~q_full_i;
  assign last   = opcode_i & (cnt_q == CNT_W'(CAL_SAMPLES - 1));

  always_comb begin
    cnt_d = cnt_q;
    if (accept && opcode_i) begin
      cnt_d = last ? '0 : cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // arithmetic shift by 4 is just the top 12 bits read as signed
  assign q_wr_o           = accept;
  assign q_wdata_o.cal    = opcode_i;
  assign q_wdata_o.last   = last;
  assign q_wdata_o.smp[0] = x_word_i[WORD_W-1:SAMPLE_SHIFT];
  assign q_wdata_o.smp[1] = y_word_i[WORD_W-1:SAMPLE_SHIFT];
  assign q_wdata_o.smp[2] = z_word_i[WORD_W-1:SAMPLE_SHIFT];

endmodule

FILE: design/aocc_queue.sv
// short command queue between front and back
`timescale 1ns / 1ps
module aocc_queue import aocc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  cmd_t wdata_i,
  output logic full_o,
  input  logic rd_i,
  output cmd_t rdata_o,
  output logic empty_o
);

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (rd_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      cnt_q <= cnt_q + QCNT_W'(wr_i) - QCNT_W'(rd_i);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= QCNT_W'(QDEPTH))
    else $error("queue count beyond depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_i && !wr_i) |=> (cnt_q == $past(cnt_q) - QCNT_W'(1)))
    else $error("queue count lost a read");

endmodule

FILE: design/aocc_back.sv
// back end: offset correction, calibration accumulators, offset divide and result buffer
`timescale 1ns / 1ps
module aocc_back import aocc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [G_W-1:0]          cfg_wdata_i,
  input  logic                    q_empty_i,
  input  cmd_t                    q_rdata_i,
  output logic                    q_rd_o,
  output logic                    empty,
  input  logic                    pop,
  output logic signed [VAL_W-1:0] x_value_o,
  output logic signed [VAL_W-1:0] y_value_o,
  output logic signed [VAL_W-1:0] z_value_o,
  output logic                    calibration_done_o
);

  div_state_e state_d, state_q;
  logic [G_W-1:0] g_q;

  logic signed [NUM_AXES-1:0][VAL_W-1:0] off_q;
  logic signed [NUM_AXES-1:0][TOT_W-1:0] tot_q;
  logic signed [NUM_AXES-1:0][TOT_W-1:0] tfin_q;
  logic [NUM_AXES-1:0][ABS_W-1:0]        abs_q;
  logic [NUM_AXES-1:0][ABS_W-1:0]        q0_q;
  logic [NUM_AXES-1:0][QUO_W-1:0]        quo_q;
  logic [NUM_AXES-1:0]                   neg_q;
  logic                                  zpos_q;

  res_t res_buf_q [2];
  logic wr_ptr_q, rd_ptr_q;
  logic [1:0] ob_cnt_q;

  logic issue;
  logic pop_ok;
  res_t res;
  logic signed [NUM_AXES-1:0][TOT_W-1:0] tsum;

  assign pop_ok = pop & ~empty;
  assign issue  = (state_q == ST_RUN) & ~q_empty_i & ((ob_cnt_q != 2'd2) | pop_ok);
  assign q_rd_o = issue;

  // per-beat result and running totals
  always_comb begin
    logic signed [SAMPLE_W-1:0] s;
    logic signed [WIDE_W-1:0]   diff;
    for (int i = 0; i < NUM_AXES; i++) begin
      s       = $signed(q_rdata_i.smp[i]);
      diff    = WIDE_W'(s) - WIDE_W'($signed(off_q[i]));
      tsum[i] = tot_q[i] + TOT_W'(s);
      res.val[i] = q_rdata_i.cal ? VAL_W'(s) : sat_val(diff);
    end
    res.done = q_rdata_i.cal & q_rdata_i.last;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_RUN:   if (issue && q_rdata_i.cal && q_rdata_i.last) state_d = ST_ABS;
      ST_ABS:   state_d = ST_MUL;
      ST_MUL:   state_d = ST_FIX;
      ST_FIX:   state_d = ST_APPLY;
      ST_APPLY: state_d = ST_RUN;
      default:  state_d = ST_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_RUN;
      g_q      <= G_RESET;
      off_q    <= '0;
      tot_q    <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      ob_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        g_q <= cfg_wdata_i;
      end
      if (issue && q_rdata_i.cal) begin
        tot_q <= q_rdata_i.last ? '0 : tsum;
      end
      if (state_q == ST_APPLY) begin
        for (int i = 0; i < NUM_AXES; i++) begin
          logic signed [WIDE_W-1:0] qs;
          qs = neg_q[i] ? -WIDE_W'(quo_q[i]) : WIDE_W'(quo_q[i]);
          if (i == NUM_AXES - 1) begin
            // z carries gravity: remove it in the direction of the total
            qs = zpos_q ? qs - WIDE_W'(g_q) : qs + WIDE_W'(g_q);
          end
          off_q[i] <= sat_val(qs);
        end
      end
      if (issue) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_ok) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      ob_cnt_q <= ob_cnt_q + 2'(issue) - 2'(pop_ok);
    end
  end

  // result buffer writes, and the divide by the sample count: reciprocal multiply, then one correction step
  always_ff @(posedge clk_i) begin
    if (issue) begin
      res_buf_q[wr_ptr_q] <= res;
    end
    if (issue && res.done) begin
      tfin_q <= tsum;
    end
    if (state_q == ST_ABS) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        neg_q[i] <= tfin_q[i][TOT_W-1];
        abs_q[i] <= tfin_q[i][TOT_W-1] ? ABS_W'(-tfin_q[i]) : ABS_W'(tfin_q[i]);
      end
      zpos_q <= ~tfin_q[NUM_AXES-1][TOT_W-1] & (tfin_q[NUM_AXES-1] != '0);
    end
    if (state_q == ST_MUL) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        logic [PROD_W-1:0] prod;
        prod    = PROD_W'(abs_q[i]) * PROD_W'(RECIP);
        q0_q[i] <= prod[RECIP_SHIFT +: ABS_W];
      end
    end
    if (state_q == ST_FIX) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        logic [ABS_W-1:0] rem;
        logic [ABS_W-1:0] quo;
        rem      = abs_q[i] - ABS_W'(q0_q[i] * ABS_W'(CAL_SAMPLES));
        quo      = q0_q[i] + ABS_W'(rem >= ABS_W'(CAL_SAMPLES));
        quo_q[i] <= quo[QUO_W-1:0];
      end
    end
  end

  assign empty              = (ob_cnt_q == '0);
  assign x_value_o          = res_buf_q[rd_ptr_q].val[0];
  assign y_value_o          = res_buf_q[rd_ptr_q].val[1];
  assign z_value_o          = res_buf_q[rd_ptr_q].val[2];
  assign calibration_done_o = res_buf_q[rd_ptr_q].done;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_APPLY) |=> $stable(off_q))
    else $error("offsets changed outside the apply step");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_RUN) |-> !q_rd_o)
    else $error("command taken while offset divide busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) ob_cnt_q <= 2'd2)
    else $error("result buffer overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && res.done) |=> (state_q == ST_ABS && tot_q == '0))
    else $error("calibration end did not start the divide");

endmodule

FILE: design/accel_offset_calibrate_correct.sv
// top level of the accelerometer offset calibration and correction block
// path: an accepted beat is written into the queue, then into the result buffer
// when the back end takes it, and stays on the result ports until it is popped
// throughput: one beat per cycle unless the queue or result buffer is full;
// a calibration end pauses the back end for the divide: abs, multiply, fix, apply
// reset: asynchronous, active low; clears offsets, totals, count and queues and
// sets the one-g value to 1024
`timescale 1ns / 1ps
module accel_offset_calibrate_correct import aocc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push,
  output logic                    full,
  input  logic                    opcode_i,
  input  logic [WORD_W-1:0]       x_word_i,
  input  logic [WORD_W-1:0]       y_word_i,
  input  logic [WORD_W-1:0]       z_word_i,
  output logic                    empty,
  input  logic                    pop,
  output logic signed [VAL_W-1:0] x_value_o,
  output logic signed [VAL_W-1:0] y_value_o,
  output logic signed [VAL_W-1:0] z_value_o,
  output logic                    calibration_done_o,
  input  logic                    cfg_we_i,
  input  logic [G_W-1:0]          cfg_wdata_i
);

  logic q_wr, q_full, q_rd, q_empty;
  cmd_t q_wdata, q_rdata;

  aocc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .opcode_i  (opcode_i),
    .x_word_i  (x_word_i),
    .y_word_i  (y_word_i),
    .z_word_i  (z_word_i),
    .q_full_i  (q_full),
    .q_wr_o    (q_wr),
    .q_wdata_o (q_wdata)
  );

  aocc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .rd_i    (q_rd),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  aocc_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .q_empty_i          (q_empty),
    .q_rdata_i          (q_rdata),
    .q_rd_o             (q_rd),
    .empty              (empty),
    .pop                (pop),
    .x_value_o          (x_value_o),
    .y_value_o          (y_value_o),
    .z_value_o          (z_value_o),
    .calibration_done_o (calibration_done_o)
  );

endmodule

FILE: tb/tb.sv
// self-checking testbench for the accelerometer offset calibration and correction block
`timescale 1ns / 1ps
module tb;
  import aocc_pkg::*;

  localparam logic OP_MEASURE    = 1'b0;
  localparam logic OP_CALIBRATE  = 1'b1;
  localparam int   CAL_N         = CAL_SAMPLES;
  localparam int   V_HI          = (1 << (VAL_W - 1)) - 1;
  localparam int   V_LO          = -V_HI - 1;
  localparam int   STALL_LIMIT   = 4000;
  localparam int   SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [VAL_W-1:0] x;
    logic [VAL_W-1:0] y;
    logic [VAL_W-1:0] z;
    logic             done;
  } reading_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              push        = 1'b0;
  logic              full;
  logic              opcode_i    = OP_MEASURE;
  logic [WORD_W-1:0] x_word_i    = '0;
  logic [WORD_W-1:0] y_word_i    = '0;
  logic [WORD_W-1:0] z_word_i    = '0;
  logic              empty;
  logic              pop         = 1'b0;
  logic [VAL_W-1:0]  x_value_o;
  logic [VAL_W-1:0]  y_value_o;
  logic [VAL_W-1:0]  z_value_o;
  logic              calibration_done_o;
  logic              cfg_we_i    = 1'b0;
  logic [G_W-1:0]    cfg_wdata_i = '0;

  // predictor state
  int offset_est[NUM_AXES] = '{default: 0};
  int cal_sum[NUM_AXES]    = '{default: 0};
  int cal_taken            = 0;
  int one_g                = int'(G_RESET);

  reading_t expected_q[$];
  int       errors         = 0;
  int       readings_sent  = 0;
  int       results_seen   = 0;
  int       cal_done_seen  = 0;
  int       send_idle_pct  = 12;
  int       recv_idle_pct  = 68;
  int       stall_cycles   = 0;

  accel_offset_calibrate_correct dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .push               (push),
    .full               (full),
    .opcode_i           (opcode_i),
    .x_word_i           (x_word_i),
    .y_word_i           (y_word_i),
    .z_word_i           (z_word_i),
    .empty              (empty),
    .pop                (pop),
    .x_value_o          (x_value_o),
    .y_value_o          (y_value_o),
    .z_value_o          (z_value_o),
    .calibration_done_o (calibration_done_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int word_sample(input logic [WORD_W-1:0] w);
    logic signed [SAMPLE_W-1:0] s;
    s = w[WORD_W-1:SAMPLE_SHIFT];
    return int'(s);
  endfunction

  function automatic int clamp14(input int v);
    if (v < V_LO) return V_LO;
    if (v > V_HI) return V_HI;
    return v;
  endfunction

  // works out the result of one reading and advances the calibration state
  function automatic reading_t correct_reading(input logic op, input logic [WORD_W-1:0] xw,
                                               input logic [WORD_W-1:0] yw,
                                               input logic [WORD_W-1:0] zw);
    int       smp[NUM_AXES];
    int       val[NUM_AXES];
    int       i;
    reading_t r;
    smp[0] = word_sample(xw);
    smp[1] = word_sample(yw);
    smp[2] = word_sample(zw);
    r.done = 1'b0;
    if (op == OP_MEASURE) begin
      for (i = 0; i < NUM_AXES; i++) val[i] = clamp14(smp[i] - offset_est[i]);
    end else begin
      for (i = 0; i < NUM_AXES; i++) begin
        val[i] = smp[i];
        cal_sum[i] += smp[i];
      end
      cal_taken++;
      if (cal_taken >= CAL_N) begin
        offset_est[0] = clamp14(cal_sum[0] / CAL_N);
        offset_est[1] = clamp14(cal_sum[1] / CAL_N);
        // gravity sits on z, so it comes off in the direction of the total
        if (cal_sum[2] > 0) offset_est[2] = clamp14(cal_sum[2] / CAL_N - one_g);
        else                offset_est[2] = clamp14(cal_sum[2] / CAL_N + one_g);
        for (i = 0; i < NUM_AXES; i++) cal_sum[i] = 0;
        cal_taken = 0;
        r.done = 1'b1;
      end
    end
    r.x = VAL_W'(val[0]);
    r.y = VAL_W'(val[1]);
    r.z = VAL_W'(val[2]);
    return r;
  endfunction

  function automatic void compare_field(input string name, input logic [VAL_W-1:0] want,
                                        input logic [VAL_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 'h%h, actual 'h%h", $time, name, want, got);
      errors++;
    end
  endfunction

  // result side: random pop stalls, checked at the rising edge
  always @(negedge clk_i) pop <= ($urandom_range(0, 99) >= recv_idle_pct);

  always @(posedge clk_i) begin
    reading_t want;
    if (rst_ni && pop && !empty) begin
      results_seen++;
      if (calibration_done_o === 1'b1) cal_done_seen++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result beat, actual x 'h%h y 'h%h z 'h%h done %b",
                 $time, x_value_o, y_value_o, z_value_o, calibration_done_o);
        errors++;
      end else begin
        want = expected_q.pop_front();
        compare_field("x_value", want.x, x_value_o);
        compare_field("y_value", want.y, y_value_o);
        compare_field("z_value", want.z, z_value_o);
        compare_field("calibration_done", VAL_W'(want.done), VAL_W'(calibration_done_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, expected_q.size());
      $display("accel_offset_calibrate_correct verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_reading(input logic op, input logic [WORD_W-1:0] xw,
                              input logic [WORD_W-1:0] yw, input logic [WORD_W-1:0] zw);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push     <= 1'b1;
    opcode_i <= op;
    x_word_i <= xw;
    y_word_i <= yw;
    z_word_i <= zw;
    do @(posedge clk_i); while (full);
    expected_q.push_back(correct_reading(op, xw, yw, zw));
    readings_sent++;
  endtask

  // hold the sender off until every result is back and the divide has settled
  task automatic wait_drained();
    @(negedge clk_i);
    push <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_one_g(input logic [G_W-1:0] g);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= g;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    one_g = int'(g);
  endtask

  function automatic logic [WORD_W-1:0] rand_word();
    logic [WORD_W-1:0] w;
    w = WORD_W'($urandom_range(0, 65535));
    case ($urandom_range(0, 7))
      0:       w[WORD_W-1:SAMPLE_SHIFT] = 12'h7FF;
      1:       w[WORD_W-1:SAMPLE_SHIFT] = 12'h800;
      2:       w[WORD_W-1:SAMPLE_SHIFT] = 12'h000;
      default: ;
    endcase
    return w;
  endfunction

  task automatic test_word_extremes();
    send_reading(OP_MEASURE, 16'h0000, 16'hFFFF, 16'h7FF0);
    send_reading(OP_MEASURE, 16'h7FF0, 16'h8000, 16'h800F);
    send_reading(OP_MEASURE, 16'hFFFF, 16'h000F, 16'h7FFF);
    send_reading(OP_MEASURE, 16'h8000, 16'h7FF0, 16'h0010);
  endtask

  // full calibration at the reset one-g value, with a measure beat in the middle
  task automatic test_reset_calibration();
    int k;
    for (k = 0; k < CAL_N; k++) begin
      if (k == CAL_N / 2) send_reading(OP_MEASURE, rand_word(), rand_word(), rand_word());
      send_reading(OP_CALIBRATE, 16'h7FF0, 16'h8000, 16'h0000);
    end
  endtask

  task automatic test_offset_correction();
    send_reading(OP_MEASURE, 16'h7FF0, 16'h8000, 16'h8000);
  endtask

  // mostly calibration runs of random length, some cut short, plus measure bursts
  task automatic test_random_traffic(input int n_items);
    int sent;
    int burst;
    int k;
    logic op;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 70) begin
        burst = $urandom_range(1, CAL_N + 5);
        for (k = 0; k < burst; k++) begin
          op = ($urandom_range(0, 99) < 15) ? OP_MEASURE : OP_CALIBRATE;
          send_reading(op, rand_word(), rand_word(), rand_word());
        end
      end else begin
        burst = $urandom_range(1, 8);
        for (k = 0; k < burst; k++)
          send_reading(OP_MEASURE, rand_word(), rand_word(), rand_word());
      end
      sent += burst;
    end
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_word_extremes();
    test_reset_calibration();
    test_offset_correction();

    write_one_g({G_W{1'b1}});
    test_random_traffic(150);

    write_one_g('0);
    send_idle_pct = 68;
    recv_idle_pct = 12;
    test_random_traffic(150);

    write_one_g(G_W'(4096));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(75);
    write_one_g(G_W'($urandom_range(0, 8191)));
    test_random_traffic(75);

    wait_drained();
    $display("%0d readings sent, %0d results checked, %0d calibrations completed",
             readings_sent, results_seen, cal_done_seen);
    $display("one-g at reset, max, zero, 4096 and random; stalls on either side and none");
    if (errors == 0) begin
      $display("accel_offset_calibrate_correct verification clean");
    end else begin
      $display("accel_offset_calibrate_correct verification failed");
    end
    $finish;
  end

endmodule
